// ----- hw/rtl/irat_pkg.sv -----
// Shared types, codes and default sizes for the interval region assign table.
package irat_pkg;

  localparam int MAX_INTERVALS_D = 16;
  localparam int POS_BITS_D      = 32;
  localparam int TAG_BITS_D      = 8;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int STATUS_W   = 2;
  localparam int OPCODE_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOLDER_LENGTH = 1'd1;

  localparam logic [OPCODE_W-1:0] OP_ASSIGN = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_RESET  = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

  typedef enum logic [3:0] {
    ST_NONE,
    ST_START,
    ST_LEFT,
    ST_NEW,
    ST_RIGHT,
    ST_TAIL_NEW,
    ST_FLUSH,
    ST_COMMIT,
    ST_LOOK,
    ST_REMOVE
  } step_t;

  typedef struct packed {
    logic  capture;
    step_t step;
  } cmd_t;

  typedef struct packed {
    logic                bad;
    logic                more;
    logic                more_next;
    logic [OPCODE_W-1:0] op;
  } stat_t;

endpackage

// ----- hw/rtl/irat_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module irat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/irat_ctrl.sv -----
// Sequencer that walks the held intervals for each operation.
module irat_ctrl import irat_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy,
  output logic  out_valid
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_RD, S_P0, S_P1, S_P2, S_TAIL, S_FLUSH, S_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, out_valid_r;
  logic   finish;

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.step    = ST_NONE;
    finish      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.step = ST_START;
        if (stat.bad) begin
          finish = 1'b1;
        end else begin
          unique case (stat.op)
            OP_ASSIGN: state_nxt = stat.more ? S_RD : S_TAIL;
            OP_LOOKUP, OP_REMOVE: begin
              if (stat.more) state_nxt = S_RD;
              else finish = 1'b1;
            end
            default: finish = 1'b1;
          endcase
        end
      end
      S_RD: state_nxt = S_P0;
      S_P0: begin
        unique case (stat.op)
          OP_ASSIGN: begin
            cmd.step  = ST_LEFT;
            state_nxt = S_P1;
          end
          OP_LOOKUP, OP_REMOVE: begin
            cmd.step = (stat.op == OP_LOOKUP) ? ST_LOOK : ST_REMOVE;
            if (stat.more_next) state_nxt = S_RD;
            else finish = 1'b1;
          end
          default: finish = 1'b1;
        endcase
      end
      S_P1: begin
        cmd.step  = ST_NEW;
        state_nxt = S_P2;
      end
      S_P2: begin
        cmd.step  = ST_RIGHT;
        state_nxt = stat.more_next ? S_RD : S_TAIL;
      end
      S_TAIL: begin
        cmd.step  = ST_TAIL_NEW;
        state_nxt = S_FLUSH;
      end
      S_FLUSH: begin
        cmd.step  = ST_FLUSH;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.step = ST_COMMIT;
        finish   = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (finish) state_nxt = S_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= (state_nxt != S_IDLE);
      out_valid_r <= finish;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

endmodule

// ----- hw/rtl/irat_dpath.sv -----
// Datapath: configuration, two table banks, piece generation and merging.
module irat_dpath import irat_pkg::*; #(
  parameter int MAX_INTERVALS = MAX_INTERVALS_D,
  parameter int POS_BITS      = POS_BITS_D,
  parameter int TAG_BITS      = TAG_BITS_D
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic [CFG_IDX_W-1:0]              cfg_index,
  input  logic [CFG_DATA_W-1:0]             cfg_wdata,
  input  logic [OPCODE_W-1:0]               in_opcode,
  input  logic [POS_BITS-1:0]               in_range_start,
  input  logic [POS_BITS-1:0]               in_range_length,
  input  logic [TAG_BITS-1:0]               in_source_tag,
  input  logic [POS_BITS-1:0]               in_query_position,
  input  cmd_t                              cmd,
  output stat_t                             stat,
  output logic [TAG_BITS-1:0]               out_found_tag,
  output logic [STATUS_W-1:0]               out_status,
  output logic [$clog2(MAX_INTERVALS+1)-1:0] out_interval_count
);

  localparam int AW   = $clog2(MAX_INTERVALS);
  localparam int CNTW = $clog2(MAX_INTERVALS + 1);
  localparam int MW   = $clog2(MAX_INTERVALS + 3);
  localparam int EW   = 2 * POS_BITS + TAG_BITS;

  // Control state.
  logic [TAG_BITS:0]      sc_r, sc_nxt;
  logic [CFG_DATA_W-1:0]  fl_r, fl_nxt;
  logic                   bank_r, bank_nxt;
  logic [CNTW-1:0]        count_r, count_nxt;

  // Operation payload and walk state.
  logic [OPCODE_W-1:0]    op_r;
  logic [POS_BITS-1:0]    s_r, len_r, q_r;
  logic [POS_BITS:0]      e_r;
  logic [TAG_BITS-1:0]    tag_r;
  logic [AW-1:0]          idx_r, idx_nxt;
  logic                   new_done_r, new_done_nxt;
  logic                   acc_v_r, acc_v_nxt;
  logic [POS_BITS:0]      acc_st_r, acc_st_nxt, acc_end_r, acc_end_nxt;
  logic [TAG_BITS-1:0]    acc_tag_r, acc_tag_nxt;
  logic [MW-1:0]          m_r, m_nxt;
  logic [TAG_BITS-1:0]    found_r, found_nxt;
  logic [STATUS_W-1:0]    status_r, status_nxt;

  // Current entry read from the active bank.
  logic [EW-1:0]          rd0, rd1, rdata;
  logic [POS_BITS-1:0]    e_st, e_len;
  logic [TAG_BITS-1:0]    e_tag;
  logic [POS_BITS:0]      e_st_x, e_en, s_x, q_x;
  logic                   left_of, right_of, overlap;

  // Piece offered to the merger.
  logic                   p_v;
  logic [POS_BITS:0]      p_st, p_en, span;
  logic [TAG_BITS-1:0]    p_tag;
  logic                   can_merge, flush_wr, merge_we;

  logic                   loc_we;
  logic [AW-1:0]          loc_addr;
  logic [EW-1:0]          loc_data, merge_data;
  logic [POS_BITS:0]      acc_len;
  logic [POS_BITS-1:0]    fl_pos;
  logic                   we0, we1;
  logic [AW-1:0]          wa0, wa1;
  logic [EW-1:0]          wd0, wd1;

  assign rdata  = bank_r ? rd1 : rd0;
  assign e_st   = rdata[EW-1 -: POS_BITS];
  assign e_len  = rdata[POS_BITS+TAG_BITS-1 -: POS_BITS];
  assign e_tag  = rdata[TAG_BITS-1:0];
  assign e_st_x = {1'b0, e_st};
  assign e_en   = {1'b0, e_st} + {1'b0, e_len};
  assign s_x    = {1'b0, s_r};
  assign q_x    = {1'b0, q_r};

  assign left_of  = (e_en <= s_x);
  assign right_of = (e_st_x >= e_r);
  assign overlap  = !left_of && !right_of;

  assign fl_pos = POS_BITS'(fl_r);

  always_comb begin
    stat.op = op_r;
    stat.bad = 1'b0;
    if (op_r == OP_ASSIGN) begin
      stat.bad = ({1'b0, tag_r} >= sc_r) || (len_r == '0) ||
                 (e_r[POS_BITS] && (e_r[POS_BITS-1:0] != '0));
    end else if (op_r == OP_REMOVE) begin
      stat.bad = ({1'b0, tag_r} >= sc_r);
    end
    stat.more      = (count_r != '0);
    stat.more_next = ((CNTW+1)'(idx_r) + (CNTW+1)'(1)) < (CNTW+1)'(count_r);
  end

  // Piece selection for the current step.
  always_comb begin
    p_v   = 1'b0;
    p_st  = e_st_x;
    p_en  = e_en;
    p_tag = e_tag;
    new_done_nxt = new_done_r;
    unique case (cmd.step)
      ST_LEFT: begin
        if (left_of) begin
          p_v = 1'b1;
        end else if (overlap && (e_st_x < s_x)) begin
          p_v  = 1'b1;
          p_en = s_x;
        end
      end
      ST_NEW, ST_TAIL_NEW: begin
        if (!new_done_r && ((cmd.step == ST_TAIL_NEW) || !left_of)) begin
          p_v          = 1'b1;
          p_st         = s_x;
          p_en         = e_r;
          p_tag        = tag_r;
          new_done_nxt = 1'b1;
        end
      end
      ST_RIGHT: begin
        if (right_of) begin
          p_v = 1'b1;
        end else if (overlap && (e_en > e_r)) begin
          p_v  = 1'b1;
          p_st = e_r;
        end
      end
      default: ;
    endcase
    if (cmd.step == ST_START) new_done_nxt = 1'b0;
  end

  // Touching same-tag pieces are joined unless the joined length overflows.
  assign span      = p_en - acc_st_r;
  assign can_merge = acc_v_r && (acc_end_r == p_st) && (acc_tag_r == p_tag) &&
                     !span[POS_BITS];
  assign flush_wr  = (cmd.step == ST_FLUSH) && acc_v_r;
  assign merge_we  = (p_v && acc_v_r && !can_merge) || flush_wr;
  assign acc_len   = acc_end_r - acc_st_r;
  assign merge_data = {acc_st_r[POS_BITS-1:0], acc_len[POS_BITS-1:0], acc_tag_r};

  always_comb begin
    acc_v_nxt   = acc_v_r;
    acc_st_nxt  = acc_st_r;
    acc_end_nxt = acc_end_r;
    acc_tag_nxt = acc_tag_r;
    m_nxt       = m_r;
    if (cmd.step == ST_START) begin
      acc_v_nxt = 1'b0;
      m_nxt     = '0;
    end else if (p_v) begin
      if (can_merge) begin
        acc_end_nxt = p_en;
      end else begin
        if (acc_v_r) m_nxt = m_r + MW'(1);
        acc_v_nxt   = 1'b1;
        acc_st_nxt  = p_st;
        acc_end_nxt = p_en;
        acc_tag_nxt = p_tag;
      end
    end else if (flush_wr) begin
      m_nxt     = m_r + MW'(1);
      acc_v_nxt = 1'b0;
    end
  end

  // Table updates, lookup, remove and configuration.
  always_comb begin
    sc_nxt     = sc_r;
    fl_nxt     = fl_r;
    bank_nxt   = bank_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    found_nxt  = found_r;
    status_nxt = status_r;
    loc_we     = 1'b0;
    loc_addr   = idx_r;
    loc_data   = {e_st, e_len, e_tag};
    if (cfg_valid) begin
      if (cfg_index == REG_SOURCE_COUNT) sc_nxt = cfg_wdata[TAG_BITS:0];
      else if (cfg_index == REG_FOLDER_LENGTH) fl_nxt = cfg_wdata;
    end
    unique case (cmd.step)
      ST_START: begin
        idx_nxt    = '0;
        found_nxt  = '0;
        status_nxt = stat.bad ? STATUS_REJECT : STATUS_DONE;
        if (op_r == OP_REMOVE && !stat.bad) sc_nxt = sc_r - (TAG_BITS+1)'(1);
        if (op_r == OP_RESET) begin
          loc_we    = 1'b1;
          loc_addr  = '0;
          loc_data  = {{POS_BITS{1'b0}}, fl_pos, {TAG_BITS{1'b0}}};
          count_nxt = (fl_pos != '0) ? CNTW'(1) : '0;
        end
      end
      ST_RIGHT: idx_nxt = idx_r + AW'(1);
      ST_LOOK: begin
        idx_nxt = idx_r + AW'(1);
        if ((q_x >= e_st_x) && (q_x < e_en)) found_nxt = e_tag;
      end
      ST_REMOVE: begin
        idx_nxt  = idx_r + AW'(1);
        loc_we   = 1'b1;
        if (e_tag == tag_r) loc_data = {e_st, e_len, {TAG_BITS{1'b0}}};
        else if (e_tag > tag_r) loc_data = {e_st, e_len, TAG_BITS'(e_tag - 1'b1)};
      end
      ST_COMMIT: begin
        if (m_r > MW'(MAX_INTERVALS)) begin
          status_nxt = STATUS_FULL;
        end else begin
          count_nxt = CNTW'(m_r);
          bank_nxt  = !bank_r;
        end
      end
      default: ;
    endcase
  end

  // Merged pieces go to the idle bank; in-place edits go to the active one.
  always_comb begin
    we0 = 1'b0;
    we1 = 1'b0;
    wa0 = loc_addr;
    wa1 = loc_addr;
    wd0 = loc_data;
    wd1 = loc_data;
    if (merge_we && (m_r < MW'(MAX_INTERVALS))) begin
      if (bank_r) begin
        we0 = 1'b1;
        wa0 = m_r[AW-1:0];
        wd0 = merge_data;
      end else begin
        we1 = 1'b1;
        wa1 = m_r[AW-1:0];
        wd1 = merge_data;
      end
    end
    if (loc_we) begin
      if (bank_r) we1 = 1'b1;
      else we0 = 1'b1;
    end
  end

  irat_ram #(.WIDTH(EW), .DEPTH(MAX_INTERVALS)) u_bank0 (
    .clk(clk), .we(we0), .waddr(wa0), .wdata(wd0), .raddr(idx_r), .rdata(rd0)
  );

  irat_ram #(.WIDTH(EW), .DEPTH(MAX_INTERVALS)) u_bank1 (
    .clk(clk), .we(we1), .waddr(wa1), .wdata(wd1), .raddr(idx_r), .rdata(rd1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r    <= '0;
      fl_r    <= '0;
      bank_r  <= 1'b0;
      count_r <= '0;
    end else begin
      sc_r    <= sc_nxt;
      fl_r    <= fl_nxt;
      bank_r  <= bank_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_opcode;
      s_r   <= in_range_start;
      len_r <= in_range_length;
      tag_r <= in_source_tag;
      q_r   <= in_query_position;
      e_r   <= {1'b0, in_range_start} + {1'b0, in_range_length};
    end
    idx_r      <= idx_nxt;
    new_done_r <= new_done_nxt;
    acc_v_r    <= acc_v_nxt;
    acc_st_r   <= acc_st_nxt;
    acc_end_r  <= acc_end_nxt;
    acc_tag_r  <= acc_tag_nxt;
    m_r        <= m_nxt;
    found_r    <= found_nxt;
    status_r   <= status_nxt;
  end

  assign out_found_tag      = found_r;
  assign out_status         = status_r;
  assign out_interval_count = count_r;

endmodule

// ----- hw/rtl/interval_region_assign_table.sv -----
// Top level of the interval region assign table.
//
// Commands enter on the in_ ports: a transfer happens at a clock edge where
// start is high and busy is low. Opcodes are assign range, lookup position,
// reset table and remove source. Each command gives one result on the out_
// ports, held for one cycle and marked by out_valid; the receiver cannot
// stall, so the result must be taken in that cycle.
// Configuration (source count, folder length) is written on the cfg_ port,
// which is always ready; write it only while the block is idle.
// One command is worked on at a time. The held intervals are read one per
// entry from the active RAM bank, whose read data is registered.
// An assign walks the table once, trimming, inserting and merging on the
// fly into the idle bank; the banks swap only when the result fits.
// After reset the table is empty and both registers are zero.
module interval_region_assign_table import irat_pkg::*; #(
  parameter int MAX_INTERVALS = MAX_INTERVALS_D,
  parameter int POS_BITS      = POS_BITS_D,
  parameter int TAG_BITS      = TAG_BITS_D
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [OPCODE_W-1:0]                in_opcode,
  input  logic [POS_BITS-1:0]                in_range_start,
  input  logic [POS_BITS-1:0]                in_range_length,
  input  logic [TAG_BITS-1:0]                in_source_tag,
  input  logic [POS_BITS-1:0]                in_query_position,
  output logic                               out_valid,
  output logic [TAG_BITS-1:0]                out_found_tag,
  output logic [STATUS_W-1:0]                out_status,
  output logic [$clog2(MAX_INTERVALS+1)-1:0] out_interval_count,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [CFG_IDX_W-1:0]               cfg_index,
  input  logic [CFG_DATA_W-1:0]              cfg_wdata
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  irat_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .stat(stat), .cmd(cmd),
    .busy(busy), .out_valid(out_valid)
  );

  irat_dpath #(
    .MAX_INTERVALS(MAX_INTERVALS), .POS_BITS(POS_BITS), .TAG_BITS(TAG_BITS)
  ) u_dpath (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_opcode(in_opcode), .in_range_start(in_range_start),
    .in_range_length(in_range_length), .in_source_tag(in_source_tag),
    .in_query_position(in_query_position),
    .cmd(cmd), .stat(stat),
    .out_found_tag(out_found_tag), .out_status(out_status),
    .out_interval_count(out_interval_count)
  );

endmodule

// ----- hw/rtl/irat_checker.sv -----
// Port-level checks for the interval region assign table, bound to the top.
module irat_checker import irat_pkg::*; #(
  parameter int MAX_INTERVALS = MAX_INTERVALS_D,
  parameter int POS_BITS      = POS_BITS_D,
  parameter int TAG_BITS      = TAG_BITS_D
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic [OPCODE_W-1:0]                in_opcode,
  input logic [POS_BITS-1:0]                in_range_start,
  input logic [POS_BITS-1:0]                in_range_length,
  input logic [TAG_BITS-1:0]                in_source_tag,
  input logic [POS_BITS-1:0]                in_query_position,
  input logic                               out_valid,
  input logic [TAG_BITS-1:0]                out_found_tag,
  input logic [STATUS_W-1:0]                out_status,
  input logic [$clog2(MAX_INTERVALS+1)-1:0] out_interval_count,
  input logic                               cfg_valid,
  input logic                               cfg_ready,
  input logic [CFG_IDX_W-1:0]               cfg_index,
  input logic [CFG_DATA_W-1:0]              cfg_wdata
);

  // An accepted command keeps the block busy until its result appears.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted command did not raise busy");

  // A result ends the command: it is shown once the block has gone idle.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy))) else $error("result outside a command");

  a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result shown for more than one cycle");

  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_status == STATUS_DONE || out_status == STATUS_REJECT ||
                    out_status == STATUS_FULL) &&
                   (out_interval_count <= MAX_INTERVALS)))
    else $error("result status or count out of range");

endmodule

bind interval_region_assign_table irat_checker #(
  .MAX_INTERVALS(MAX_INTERVALS), .POS_BITS(POS_BITS), .TAG_BITS(TAG_BITS)
) u_irat_checker (.*);

// ----- test/tb_interval_region_assign_table.sv -----
// Self-checking testbench for the interval region assign table.
`timescale 1ns / 1ps

module tb_interval_region_assign_table;
  import irat_pkg::*;

  localparam int NMAX = 16;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] rs;
    logic [31:0] rl;
    logic [7:0]  tg;
    logic [31:0] qp;
    bit          typed;
    logic [7:0]  e_tag;
    logic [1:0]  e_status;
    logic [4:0]  e_count;
  } cmd_row_t;

  typedef struct {
    logic [7:0] tag;
    logic [1:0] status;
    logic [4:0] count;
  } table_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_opcode = '0;
  logic [31:0] in_range_start = '0;
  logic [31:0] in_range_length = '0;
  logic [7:0] in_source_tag = '0;
  logic [31:0] in_query_position = '0;
  logic out_valid;
  logic [7:0] out_found_tag;
  logic [1:0] out_status;
  logic [4:0] out_interval_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  interval_region_assign_table dut (.*);

  // Predictor copy of the table and registers.
  logic [8:0]  mdl_source_count;
  logic [31:0] mdl_folder_length;
  logic [63:0] mdl_start[NMAX];
  logic [63:0] mdl_len[NMAX];
  logic [7:0]  mdl_tag[NMAX];
  int          mdl_count;

  table_reply_t pending_replies[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_full = 0;
  int n_reject = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d replies pending", pending_replies.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic table_reply_t predict_table(logic [1:0] op, logic [31:0] rs,
                                                 logic [31:0] rl, logic [7:0] tg,
                                                 logic [31:0] qp);
    table_reply_t r;
    logic [63:0] ws[$], wl[$], ms[$], ml[$];
    logic [7:0] wt[$], mt[$];
    logic [63:0] s, e, st, en, ks, kl;
    logic [7:0] kt;
    int j;
    r.tag = '0;
    r.status = STATUS_DONE;
    case (op)
      OP_ASSIGN: begin
        s = 64'(rs);
        e = 64'(rs) + 64'(rl);
        if (9'(tg) >= mdl_source_count || rl == 0 || e > 64'h1_0000_0000) begin
          r.status = STATUS_REJECT;
        end else begin
          for (int i = 0; i < mdl_count; i++) begin
            st = mdl_start[i];
            en = st + mdl_len[i];
            if (en <= s || st >= e) begin
              ws = {ws, st}; wl = {wl, mdl_len[i]}; wt = {wt, mdl_tag[i]};
            end else begin
              if (st < s) begin
                ws = {ws, st}; wl = {wl, s - st}; wt = {wt, mdl_tag[i]};
              end
              if (en > e) begin
                ws = {ws, e}; wl = {wl, en - e}; wt = {wt, mdl_tag[i]};
              end
            end
          end
          ws = {ws, s}; wl = {wl, 64'(rl)}; wt = {wt, tg};
          for (int i = 1; i < ws.size(); i++) begin
            ks = ws[i]; kl = wl[i]; kt = wt[i];
            j = i;
            while (j > 0 && ws[j-1] > ks) begin
              ws[j] = ws[j-1]; wl[j] = wl[j-1]; wt[j] = wt[j-1];
              j--;
            end
            ws[j] = ks; wl[j] = kl; wt[j] = kt;
          end
          for (int i = 0; i < ws.size(); i++) begin
            if (ms.size() > 0 && ms[$] + ml[$] == ws[i] && mt[$] == wt[i] &&
                ml[$] + wl[i] <= 64'hFFFF_FFFF) begin
              ml[ml.size()-1] = ml[$] + wl[i];
            end else begin
              ms = {ms, ws[i]}; ml = {ml, wl[i]}; mt = {mt, wt[i]};
            end
          end
          if (ms.size() > NMAX) begin
            r.status = STATUS_FULL;
          end else begin
            for (int i = 0; i < ms.size(); i++) begin
              mdl_start[i] = ms[i]; mdl_len[i] = ml[i]; mdl_tag[i] = mt[i];
            end
            mdl_count = ms.size();
          end
        end
      end
      OP_LOOKUP: begin
        for (int i = mdl_count - 1; i >= 0; i--) begin
          if (64'(qp) >= mdl_start[i] && 64'(qp) < mdl_start[i] + mdl_len[i])
            r.tag = mdl_tag[i];
        end
      end
      OP_RESET: begin
        mdl_count = (mdl_folder_length != 0) ? 1 : 0;
        mdl_start[0] = '0;
        mdl_len[0] = 64'(mdl_folder_length);
        mdl_tag[0] = '0;
      end
      default: begin
        if (9'(tg) >= mdl_source_count) begin
          r.status = STATUS_REJECT;
        end else begin
          for (int i = 0; i < mdl_count; i++) begin
            if (mdl_tag[i] == tg) mdl_tag[i] = '0;
            else if (mdl_tag[i] > tg) mdl_tag[i] = mdl_tag[i] - 8'd1;
          end
          mdl_source_count = mdl_source_count - 9'd1;
        end
      end
    endcase
    r.count = 5'(mdl_count);
    return r;
  endfunction

  task automatic idle_cycles(int n);
    repeat (n) @(posedge clk);
  endtask

  task automatic write_register(logic [0:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_SOURCE_COUNT) mdl_source_count = data[8:0];
    else mdl_folder_length = data;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    idle_cycles(4);
  endtask

  // Issues one command; a typed row overrides the predicted value for checking.
  // Start stays high after a transfer when the next command follows at once.
  task automatic send_command(cmd_row_t c);
    table_reply_t r;
    int n;
    n = $urandom_range(0, 5);
    if (n > 0) begin
      start <= 1'b0;
      idle_cycles(n);
    end
    start <= 1'b1;
    in_opcode <= c.op;
    in_range_start <= c.rs;
    in_range_length <= c.rl;
    in_source_tag <= c.tg;
    in_query_position <= c.qp;
    do @(posedge clk); while (busy);
    r = predict_table(c.op, c.rs, c.rl, c.tg, c.qp);
    if (c.typed && (r.tag != c.e_tag || r.status != c.e_status || r.count != c.e_count))
      $display("%0t: directed row disagrees with predictor", $time);
    if (c.typed) begin
      r.tag = c.e_tag; r.status = c.e_status; r.count = c.e_count;
    end
    pending_replies = {pending_replies, r};
    n_sent++;
  endtask

  always @(posedge clk) begin
    table_reply_t x;
    if (rst_n && out_valid) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected reply tag=%0d status=%0d count=%0d", $time,
                 out_found_tag, out_status, out_interval_count);
        errors++;
      end else begin
        x = pending_replies.pop_front();
        n_checked++;
        if (out_status == STATUS_FULL) n_full++;
        if (out_status == STATUS_REJECT) n_reject++;
        if (out_found_tag !== x.tag) begin
          $display("%0t: found_tag expected %0d actual %0d", $time, x.tag, out_found_tag);
          errors++;
        end
        if (out_status !== x.status) begin
          $display("%0t: status expected %0d actual %0d", $time, x.status, out_status);
          errors++;
        end
        if (out_interval_count !== x.count) begin
          $display("%0t: interval_count expected %0d actual %0d", $time, x.count,
                   out_interval_count);
          errors++;
        end
      end
    end
  end

  function automatic cmd_row_t row(logic [1:0] op, logic [31:0] rs, logic [31:0] rl,
                                   logic [7:0] tg, logic [31:0] qp, bit typed = 0,
                                   logic [7:0] et = 0, logic [1:0] es = 0,
                                   logic [4:0] ec = 0);
    cmd_row_t c;
    c.op = op; c.rs = rs; c.rl = rl; c.tg = tg; c.qp = qp;
    c.typed = typed; c.e_tag = et; c.e_status = es; c.e_count = ec;
    return c;
  endfunction

  function automatic logic [31:0] rand_pos(int span);
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: return 32'hFFFF_FFFF - $urandom_range(0, span);
      default: return $urandom_range(0, span);
    endcase
  endfunction

  function automatic cmd_row_t random_command(int span);
    cmd_row_t c;
    int pick;
    logic [31:0] s;
    pick = $urandom_range(0, 99);
    s = rand_pos(span);
    c = row(OP_ASSIGN, s, 32'($urandom_range(1, span / 4 + 1)),
            8'($urandom_range(0, 7)), rand_pos(span));
    if (pick < 5) c.rl = $urandom();
    else if (pick < 8) c.rl = '0;
    else if (pick < 11) c.tg = 8'($urandom());
    else if (pick < 12) c.rl = 32'hFFFF_FFFF - s + 32'($urandom_range(0, 1));
    else if (pick < 40) c.op = OP_LOOKUP;
    else if (pick < 44) c.op = OP_RESET;
    else if (pick < 47) begin
      c.op = OP_REMOVE;
      if ($urandom_range(0, 2) == 0) c.tg = 8'($urandom());
    end
    return c;
  endfunction

  initial begin
    cmd_row_t directed[$];
    int phase_items;
    mdl_source_count = '0;
    mdl_folder_length = '0;
    mdl_count = 0;
    idle_cycles(7);
    rst_n <= 1'b1;
    @(posedge clk);

    // With both registers zero, every assign and remove is refused.
    directed = {directed, row(OP_LOOKUP, 0, 0, 0, 0, 1, 0, STATUS_DONE, 0)};
    directed = {directed, row(OP_ASSIGN, 0, 1, 0, 0, 1, 0, STATUS_REJECT, 0)};
    directed = {directed, row(OP_REMOVE, 0, 0, 0, 0, 1, 0, STATUS_REJECT, 0)};
    directed = {directed, row(OP_RESET, 0, 0, 0, 0, 1, 0, STATUS_DONE, 0)};
    foreach (directed[i]) send_command(directed[i]);
    wait_drained();

    write_register(REG_SOURCE_COUNT, 32'd256);
    write_register(REG_FOLDER_LENGTH, 32'hFFFF_FFFF);
    directed = {};
    directed = {directed, row(OP_RESET, 0, 0, 0, 0, 1, 0, STATUS_DONE, 1)};
    directed = {directed, row(OP_LOOKUP, 0, 0, 0, 32'hFFFF_FFFE, 1, 0, STATUS_DONE, 1)};
    directed = {directed, row(OP_LOOKUP, 0, 0, 0, 32'hFFFF_FFFF, 1, 0, STATUS_DONE, 1)};
    directed = {directed,
                row(OP_ASSIGN, 32'hFFFF_FFFF, 1, 8'd255, 0, 1, 0, STATUS_DONE, 2)};
    directed = {directed,
                row(OP_LOOKUP, 0, 0, 0, 32'hFFFF_FFFF, 1, 8'd255, STATUS_DONE, 2)};
    directed = {directed,
                row(OP_ASSIGN, 32'hFFFF_FFFF, 2, 8'd1, 0, 1, 0, STATUS_REJECT, 2)};
    directed = {directed, row(OP_ASSIGN, 5, 0, 8'd1, 0, 1, 0, STATUS_REJECT, 2)};
    // Overwrite the top cell with tag 0: merging would need a 2^32 length.
    directed = {directed, row(OP_ASSIGN, 32'hFFFF_FFFF, 1, 8'd0, 0)};
    directed = {directed, row(OP_ASSIGN, 0, 32'hFFFF_FFFF, 8'd0, 0)};
    directed = {directed, row(OP_ASSIGN, 100, 50, 8'd3, 0)};
    directed = {directed, row(OP_ASSIGN, 150, 50, 8'd3, 0)};
    directed = {directed, row(OP_ASSIGN, 120, 10, 8'd7, 0)};
    directed = {directed, row(OP_LOOKUP, 0, 0, 0, 125)};
    directed = {directed, row(OP_REMOVE, 0, 0, 8'd3, 0)};
    directed = {directed, row(OP_LOOKUP, 0, 0, 0, 125)};
    directed = {directed, row(OP_REMOVE, 0, 0, 8'd255, 0, 1, 0, STATUS_REJECT, 0)};
    foreach (directed[i]) begin
      if (directed[i].op == OP_REMOVE && directed[i].typed)
        directed[i].e_count = 5'(mdl_count);
      send_command(directed[i]);
    end
    // Fragment the table until an assign comes back full.
    for (int i = 0; i < 20; i++)
      send_command(row(OP_ASSIGN, 32'(1000 + 4 * i), 2, 8'(i % 2 + 1), 0));
    wait_drained();

    // Random phases, each under a different register setting.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: write_register(REG_SOURCE_COUNT, 32'd0);
        1: write_register(REG_SOURCE_COUNT, 32'd1);
        default: write_register(REG_SOURCE_COUNT, 32'($urandom_range(2, 9)));
      endcase
      case (ph % 3)
        0: write_register(REG_FOLDER_LENGTH, 32'($urandom_range(1, 2000)));
        1: write_register(REG_FOLDER_LENGTH, 32'd0);
        default: write_register(REG_FOLDER_LENGTH, $urandom());
      endcase
      if (ph == 7) write_register(REG_SOURCE_COUNT, 32'd256);
      phase_items = 50;
      for (int i = 0; i < phase_items; i++) send_command(random_command(500));
      wait_drained();
    end

    $display("Sent %0d commands, checked %0d replies (%0d rejected, %0d table full).",
             n_sent, n_checked, n_reject, n_full);
    if (errors == 0 && pending_replies.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/irat_pkg.sv
hw/rtl/irat_ram.sv
hw/rtl/irat_ctrl.sv
hw/rtl/irat_dpath.sv
hw/rtl/interval_region_assign_table.sv
hw/rtl/irat_checker.sv
test/tb_interval_region_assign_table.sv
